### src/afr_pkg.sv
// Shared types and constants for the AX.25 fragment reassembler.
`timescale 1ns / 1ps
package afr_pkg;

    localparam int FRAG_BYTES   = 250;
    localparam int BUF_BYTES    = 2048;
    localparam int HEADER_BYTES = 18;

    localparam int POS_W   = 12;
    localparam int ADDR_W  = 11;
    localparam int LEN_W   = 12;
    localparam int CALC_W  = 13;
    localparam int CALL_W  = 48;
    localparam int SSID_W  = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [POS_W-1:0] POS_MAX      = 12'd4095;
    localparam logic [POS_W-1:0] POS_CALL_END = 12'd6;
    localparam logic [POS_W-1:0] POS_SSID     = 12'd6;
    localparam logic [POS_W-1:0] POS_CONTROL  = 12'd16;
    localparam logic [POS_W-1:0] POS_FRAG     = 12'd17;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HEADER_BYTES);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CONTROL_UI = 8'h01;

    localparam logic [0:0] CFG_DEST_CALLSIGN = 1'b0;
    localparam logic [0:0] CFG_DEST_SSID     = 1'b1;

    localparam logic [CALL_W-1:0] CALLSIGN_RESET = 48'h202020202020;

    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef struct packed {
        logic              have_write;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              done;
        logic [LEN_W-1:0]  total;
    } t_entry;

endpackage

### src/afr_front.sv
// Front end: header decode, address filter and per-byte result classification.
`timescale 1ns / 1ps
module afr_front
    import afr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_write,
    input  logic [0:0]        i_cfg_index,
    input  logic [CALL_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_frame_last,
    output logic              o_push,
    output t_entry            o_entry
);

    logic [CALL_W-1:0] r_dest_callsign;
    logic [SSID_W-1:0] r_dest_ssid;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_match, n_match;
    logic             r_accepted, n_accepted;
    logic             r_cs_ended, n_cs_ended;
    logic             r_eop, n_eop;
    logic [2:0]       r_frag, n_frag;

    logic [7:0]        w_cfg_char [8];
    logic [7:0]        w_cfg_end;
    logic [7:0]        w_c;
    logic [2:0]        w_sel;
    logic              w_have_write;
    logic              w_done;
    logic [CALC_W-1:0] w_addr_full;
    logic [CALC_W-1:0] w_total_full;
    logic [LEN_W-1:0]  w_total;

    always_comb begin
        logic prev;
        prev = 1'b0;
        w_cfg_char[6] = '0;
        w_cfg_char[7] = '0;
        w_cfg_end[7:6] = '0;
        for (int k = 0; k < 6; k++) begin
            w_cfg_char[k] = r_dest_callsign[8*(5-k) +: 8];
            w_cfg_end[k]  = prev | (w_cfg_char[k] == CHAR_SPACE) | (w_cfg_char[k] == CHAR_NUL);
            prev          = w_cfg_end[k];
        end
    end

    assign w_c   = {1'b0, i_frame_byte[7:1]};
    assign w_sel = r_pos[2:0];

    always_comb begin
        n_pos        = r_pos;
        n_match      = r_match;
        n_accepted   = r_accepted;
        n_cs_ended   = r_cs_ended;
        n_eop        = r_eop;
        n_frag       = r_frag;
        w_have_write = 1'b0;
        w_addr_full  = CALC_W'({10'd0, r_frag}) * CALC_W'(FRAG_BYTES)
                     + CALC_W'(r_pos - POS_PAYLOAD);

        if (r_pos < POS_CALL_END) begin
            n_cs_ended = r_cs_ended | (w_c == CHAR_SPACE) | (w_c == CHAR_NUL);
            if (w_cfg_end[w_sel] != n_cs_ended) begin
                n_match = 1'b0;
            end else if (!w_cfg_end[w_sel] && (w_c != w_cfg_char[w_sel])) begin
                n_match = 1'b0;
            end
        end else if (r_pos == POS_SSID) begin
            if (i_frame_byte[4:1] != r_dest_ssid) begin
                n_match = 1'b0;
            end
        end else if (r_pos == POS_CONTROL) begin
            if (i_frame_byte != CONTROL_UI) begin
                n_match = 1'b0;
            end
        end else if (r_pos == POS_FRAG) begin
            n_accepted = r_match;
            n_eop      = i_frame_byte[7];
            n_frag     = i_frame_byte[2:0];
        end else if ((r_pos >= POS_PAYLOAD) && r_accepted && (r_pos < POS_MAX)) begin
            w_have_write = (w_addr_full < CALC_W'(BUF_BYTES));
        end

        w_done       = i_frame_last && n_accepted && n_eop && (r_pos >= POS_FRAG);
        w_total_full = CALC_W'({10'd0, n_frag}) * CALC_W'(FRAG_BYTES)
                     + CALC_W'(r_pos - POS_FRAG);
        if (w_total_full > CALC_W'(BUF_BYTES)) begin
            w_total = LEN_W'(BUF_BYTES);
        end else begin
            w_total = w_total_full[LEN_W-1:0];
        end

        if (i_frame_last) begin
            n_pos      = '0;
            n_match    = 1'b1;
            n_accepted = 1'b0;
            n_cs_ended = 1'b0;
            n_eop      = 1'b0;
            n_frag     = '0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_push           = i_accept && (w_have_write || w_done);
    assign o_entry.have_write = w_have_write;
    assign o_entry.addr     = w_addr_full[ADDR_W-1:0];
    assign o_entry.data     = i_frame_byte;
    assign o_entry.done     = w_done;
    assign o_entry.total    = w_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_callsign <= CALLSIGN_RESET;
            r_dest_ssid     <= '0;
            r_pos           <= '0;
            r_match         <= 1'b1;
            r_accepted      <= 1'b0;
            r_cs_ended      <= 1'b0;
            r_eop           <= 1'b0;
            r_frag          <= '0;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_DEST_CALLSIGN: r_dest_callsign <= i_cfg_data;
                    CFG_DEST_SSID:     r_dest_ssid     <= i_cfg_data[SSID_W-1:0];
                    default:           r_dest_ssid     <= r_dest_ssid;
                endcase
            end
            if (i_accept) begin
                r_pos      <= n_pos;
                r_match    <= n_match;
                r_accepted <= n_accepted;
                r_cs_ended <= n_cs_ended;
                r_eop      <= n_eop;
                r_frag     <= n_frag;
            end
        end
    end

endmodule

### src/afr_queue.sv
// Short FIFO of classified entries between the front and back ends.
`timescale 1ns / 1ps
module afr_queue
    import afr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_head_valid,
    output t_entry o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_full       = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/afr_back.sv
// Back end: expand queue entries into results behind an output register.
`timescale 1ns / 1ps
module afr_back
    import afr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_entry            i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_result_kind,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [7:0]        o_write_data,
    output logic [LEN_W-1:0]  o_packet_length,
    output logic              o_result_last
);

    logic r_valid;
    logic r_phase;
    logic r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_data;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;

    logic w_load;
    logic w_emit_write;
    logic w_split;

    assign w_load       = i_head_valid && (!r_valid || i_out_ready);
    assign w_emit_write = i_head.have_write && !r_phase;
    assign w_split      = w_emit_write && i_head.done;
    assign o_pop        = w_load && !w_split;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_emit_write) begin
                r_kind <= KIND_WRITE;
                r_addr <= i_head.addr;
                r_data <= i_head.data;
                r_len  <= '0;
                r_last <= !i_head.done;
            end else begin
                r_kind <= KIND_COMPLETE;
                r_addr <= '0;
                r_data <= '0;
                r_len  <= i_head.total;
                r_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_phase <= w_split;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_valid;
    assign o_result_kind   = r_kind;
    assign o_write_address = r_addr;
    assign o_write_data    = r_data;
    assign o_packet_length = r_len;
    assign o_result_last   = r_last;

endmodule

### src/ax25_fragment_reassembler_top.sv
// Top level of the AX.25 address filter and fragment reassembler.
// Throughput: one frame byte per cycle while the queue is not full; a byte that
// ends a packet with a write yields two results, a write and then a completion.
// Each result is registered in the queue and then in the output register, which
// holds it while the output stalls. A four-entry queue decouples byte intake from result delivery.
// Reset: synchronous, clears frame state, queue and output; the callsign
// register returns to six spaces and the SSID register to zero.
`timescale 1ns / 1ps
module ax25_fragment_reassembler_top
    import afr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [0:0]        i_cfg_index,
    input  logic [CALL_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_frame_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_result_kind,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [7:0]        o_write_data,
    output logic [LEN_W-1:0]  o_packet_length,
    output logic              o_result_last
);

    logic   w_accept;
    logic   w_push;
    t_entry w_entry;
    logic   w_full;
    logic   w_pop;
    logic   w_head_valid;
    t_entry w_head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !w_full;
    assign w_accept    = i_in_valid && o_in_ready;

    afr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_write  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_frame_byte (i_frame_byte),
        .i_frame_last (i_frame_last),
        .o_push       (w_push),
        .o_entry      (w_entry)
    );

    afr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_entry      (w_entry),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    afr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_packet_length (o_packet_length),
        .o_result_last   (o_result_last)
    );

endmodule

### src/afr_checker.sv
// Port-level assertions for the reassembler top level, with bind.
`timescale 1ns / 1ps
module afr_checker
    import afr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_result_kind,
    input logic [ADDR_W-1:0] o_write_address,
    input logic [7:0]        o_write_data,
    input logic [LEN_W-1:0]  o_packet_length,
    input logic              o_result_last
);

    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_write_address) && $stable(o_write_data)
            && $stable(o_packet_length) && $stable(o_result_last))
        else $error("stalled result changed");

    a_complete_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_COMPLETE) |->
            (o_write_address == '0) && (o_write_data == '0) && o_result_last
            && (o_packet_length <= LEN_W'(BUF_BYTES)))
        else $error("malformed completion item");

    a_write_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_WRITE) |-> (o_packet_length == '0))
        else $error("write item carries a length");

    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_result_last |=>
            o_out_valid && (o_result_kind == KIND_COMPLETE))
        else $error("completion does not follow its write");

endmodule

bind ax25_fragment_reassembler_top afr_checker u_afr_checker (.*);
